// ===== design/bmp2rgb_pkg.sv =====
package bmp2rgb_pkg;

    // BMP header layout: fixed 54-byte header, width and height are
    // 32-bit little-endian fields.
    localparam int HEADER_BYTES  = 54;
    localparam int WIDTH_BYTE0   = 18;
    localparam int HEIGHT_BYTE0  = 22;
    localparam int HDR_IDX_W     = 6;

    // Default built maximums for the image dimensions.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Field widths of the streams.
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 20;
    localparam int COLOR_W    = 16;
    localparam int DIM_FULL_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    // RGB565 component widths.
    localparam int BLUE_W  = 5;
    localparam int GREEN_W = 6;
    localparam int RED_W   = 5;

    // Transparent key color (in 5/6/5 component space).
    localparam logic [BLUE_W-1:0]  KEY_BLUE  = 5'h1E;
    localparam logic [GREEN_W-1:0] KEY_GREEN = 6'h00;
    localparam logic [RED_W-1:0]   KEY_RED   = 5'h1E;

    // Component order within one pixel triple.
    localparam logic [1:0] COMP_BLUE  = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_RED   = 2'd2;

endpackage

// ===== design/bmp24_to_rgb565_stream_parser_top.sv =====
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+-----------------------------------------
// s (byte) | in  | i_s_tvalid, o_s_tready | i_s_tdata: data_byte; i_s_tuser: file_start
// m (pix)  | out | o_m_tvalid, i_m_tready | o_m_tdata: pixel_address, pixel_color;
//          |     |                        | o_m_tlast: is_last; o_m_tuser: oversize
//
// One byte is taken per cycle unless a stalled sink holds the pixel; each byte updates
// the parser counters in the same cycle and any pixel it completes lands in the output
// register in the next cycle. The output register is the only stage, so a byte is
// accepted while a pixel waits whenever the sink takes that pixel in the same cycle.
// Reset (i_rst_n low, synchronous) puts the parser at header byte 0 with no
// pixel pending; a byte with file_start set restarts parsing at header byte 0 but keeps any pending pixel.
// A stalled sink holds the pixel and blocks new bytes until it is taken.
module bmp24_to_rgb565_stream_parser_top #(
    parameter int MAX_WIDTH  = bmp2rgb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp2rgb_pkg::DEF_MAX_HEIGHT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Byte stream in.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bmp2rgb_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] data_byte
    input  logic                             i_s_tuser,  // [0] file_start
    // Pixel stream out.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bmp2rgb_pkg::M_TDATA_W-1:0] o_m_tdata,  // [19:0] pixel_address,
                                                          // [35:20] pixel_color,
                                                          // [39:36] zero
    output logic                             o_m_tlast,  // is_last
    output logic                             o_m_tuser   // [0] oversize
);

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int PW     = WW + HW;
    localparam int AW_EXT = (PW > bmp2rgb_pkg::ADDR_W) ? PW : bmp2rgb_pkg::ADDR_W;
    localparam int HIW    = bmp2rgb_pkg::HDR_IDX_W;
    localparam int FW     = bmp2rgb_pkg::DIM_FULL_W;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_DONE
    } t_phase;

    // Parser state.
    t_phase                               r_phase, n_phase;
    logic [HIW-1:0]                       r_hidx, n_hidx;
    logic [WW-1:0]                        r_width, n_width;
    logic                                 r_wbig, n_wbig;
    logic [HW-1:0]                        r_height, n_height;
    logic                                 r_hbig, n_hbig;
    logic [WW-1:0]                        r_col, n_col;
    logic [HW-1:0]                        r_row, n_row;
    logic [1:0]                           r_comp, n_comp;
    logic [bmp2rgb_pkg::BLUE_W-1:0]       r_blue, n_blue;
    logic [bmp2rgb_pkg::GREEN_W-1:0]      r_green, n_green;
    logic [bmp2rgb_pkg::ADDR_W-1:0]       r_next_addr, n_next_addr;
    logic [1:0]                           r_pad, n_pad;

    // Output register.
    logic                                 r_o_valid, n_o_valid;
    logic [bmp2rgb_pkg::ADDR_W-1:0]       r_o_addr, n_o_addr;
    logic [bmp2rgb_pkg::COLOR_W-1:0]      r_o_color, n_o_color;
    logic                                 r_o_last, n_o_last;
    logic                                 r_o_over, n_o_over;

    // Working values.
    logic                                 s_accept;
    logic                                 start;
    t_phase                               c_phase;
    logic [HIW-1:0]                       c_hidx;
    logic [WW-1:0]                        c_width;
    logic                                 c_wbig;
    logic [HW-1:0]                        c_height;
    logic                                 c_hbig;
    logic [1:0]                           byte_ofs;
    logic [FW-1:0]                        shifted;
    logic                                 in_width_field;
    logic                                 in_height_field;
    logic [AW_EXT-1:0]                    total_m1;
    logic [bmp2rgb_pkg::RED_W-1:0]        red;
    logic [WW-1:0]                        col_inc;
    logic [HW-1:0]                        row_inc;
    logic                                 too_big;

    assign o_s_tready = !r_o_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign start      = i_s_tuser;

    // A file-start byte sees the parser as freshly restarted.
    assign c_phase  = start ? PH_HEADER : r_phase;
    assign c_hidx   = start ? '0 : r_hidx;
    assign c_width  = start ? '0 : r_width;
    assign c_wbig   = start ? 1'b0 : r_wbig;
    assign c_height = start ? '0 : r_height;
    assign c_hbig   = start ? 1'b0 : r_hbig;

    // Byte lane inside a dimension field. The height field starts four bytes
    // after the width field, so the low two bits serve both.
    assign byte_ofs        = 2'(c_hidx - HIW'(bmp2rgb_pkg::WIDTH_BYTE0));
    assign shifted         = FW'(i_s_tdata) << {byte_ofs, 3'b000};
    assign in_width_field  = (c_hidx >= HIW'(bmp2rgb_pkg::WIDTH_BYTE0))
                          && (c_hidx < HIW'(bmp2rgb_pkg::HEIGHT_BYTE0));
    assign in_height_field = (c_hidx >= HIW'(bmp2rgb_pkg::HEIGHT_BYTE0))
                          && (c_hidx < HIW'(bmp2rgb_pkg::HEIGHT_BYTE0 + 4));

    // Pixel count minus one gives the first (highest) address.
    assign total_m1 = AW_EXT'(c_width) * AW_EXT'(c_height) - AW_EXT'(1);
    assign too_big  = c_wbig || c_hbig
                   || (c_width > WW'(MAX_WIDTH)) || (c_height > HW'(MAX_HEIGHT));

    assign red     = i_s_tdata[7:3];
    assign col_inc = WW'(r_col + 1'b1);
    assign row_inc = HW'(r_row + 1'b1);

    // Next-state and result logic for one accepted byte.
    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_width     = r_width;
        n_wbig      = r_wbig;
        n_height    = r_height;
        n_hbig      = r_hbig;
        n_col       = r_col;
        n_row       = r_row;
        n_comp      = r_comp;
        n_blue      = r_blue;
        n_green     = r_green;
        n_next_addr = r_next_addr;
        n_pad       = r_pad;
        n_o_valid   = r_o_valid && !i_m_tready;
        n_o_addr    = r_o_addr;
        n_o_color   = r_o_color;
        n_o_last    = r_o_last;
        n_o_over    = r_o_over;

        if (s_accept) begin
            n_phase  = c_phase;
            n_hidx   = c_hidx;
            n_width  = c_width;
            n_wbig   = c_wbig;
            n_height = c_height;
            n_hbig   = c_hbig;

            unique case (c_phase)
                PH_HEADER: begin
                    if (in_width_field) begin
                        n_width = c_width | shifted[WW-1:0];
                        n_wbig  = c_wbig | (|shifted[FW-1:WW]);
                    end else if (in_height_field) begin
                        n_height = c_height | shifted[HW-1:0];
                        n_hbig   = c_hbig | (|shifted[FW-1:HW]);
                    end
                    n_hidx = HIW'(c_hidx + 1'b1);
                    if (c_hidx == HIW'(bmp2rgb_pkg::HEADER_BYTES - 1)) begin
                        n_hidx = '0;
                        if (too_big) begin
                            // Single oversize report, then wait for the next file.
                            n_phase   = PH_DONE;
                            n_o_valid = 1'b1;
                            n_o_addr  = '0;
                            n_o_color = '0;
                            n_o_last  = 1'b0;
                            n_o_over  = 1'b1;
                        end else if (c_width == '0 || c_height == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase     = PH_PIXEL;
                            n_col       = '0;
                            n_row       = '0;
                            n_comp      = bmp2rgb_pkg::COMP_BLUE;
                            n_next_addr = total_m1[bmp2rgb_pkg::ADDR_W-1:0];
                        end
                    end
                end
                PH_PIXEL: begin
                    if (r_comp == bmp2rgb_pkg::COMP_BLUE) begin
                        n_blue = i_s_tdata[7:3];
                        n_comp = bmp2rgb_pkg::COMP_GREEN;
                    end else if (r_comp == bmp2rgb_pkg::COMP_GREEN) begin
                        n_green = i_s_tdata[7:2];
                        n_comp  = bmp2rgb_pkg::COMP_RED;
                    end else begin
                        // Red byte completes the pixel.
                        n_comp    = bmp2rgb_pkg::COMP_BLUE;
                        n_o_valid = 1'b1;
                        n_o_addr  = r_next_addr;
                        n_o_over  = 1'b0;
                        n_o_last  = (row_inc == r_height) && (col_inc == r_width);
                        if (r_blue == bmp2rgb_pkg::KEY_BLUE
                                && r_green == bmp2rgb_pkg::KEY_GREEN
                                && red == bmp2rgb_pkg::KEY_RED) begin
                            n_o_color = '0;
                        end else begin
                            n_o_color = {red, r_green, r_blue};
                        end
                        n_next_addr = r_next_addr - 1'b1;
                        n_col       = col_inc;
                        if (col_inc == r_width) begin
                            n_col = '0;
                            n_row = row_inc;
                            n_pad = 2'(r_width);
                            if (2'(r_width) != 2'd0) begin
                                n_phase = PH_PAD;
                            end else if (row_inc >= r_height) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_PIXEL;
                            end
                        end
                    end
                end
                PH_PAD: begin
                    n_pad = r_pad - 1'b1;
                    if (n_pad == 2'd0) begin
                        n_phase = (r_row >= r_height) ? PH_DONE : PH_PIXEL;
                    end
                end
                PH_DONE: begin
                    // Bytes are dropped until the next file start.
                end
            endcase
        end
    end

    // State and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hidx      <= '0;
            r_width     <= '0;
            r_wbig      <= 1'b0;
            r_height    <= '0;
            r_hbig      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_comp      <= bmp2rgb_pkg::COMP_BLUE;
            r_blue      <= '0;
            r_green     <= '0;
            r_next_addr <= '0;
            r_pad       <= '0;
            r_o_valid   <= 1'b0;
            r_o_addr    <= '0;
            r_o_color   <= '0;
            r_o_last    <= 1'b0;
            r_o_over    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_width     <= n_width;
            r_wbig      <= n_wbig;
            r_height    <= n_height;
            r_hbig      <= n_hbig;
            r_col       <= n_col;
            r_row       <= n_row;
            r_comp      <= n_comp;
            r_blue      <= n_blue;
            r_green     <= n_green;
            r_next_addr <= n_next_addr;
            r_pad       <= n_pad;
            r_o_valid   <= n_o_valid;
            r_o_addr    <= n_o_addr;
            r_o_color   <= n_o_color;
            r_o_last    <= n_o_last;
            r_o_over    <= n_o_over;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = bmp2rgb_pkg::M_TDATA_W'({r_o_color, r_o_addr});
    assign o_m_tlast  = r_o_last;
    assign o_m_tuser  = r_o_over;

    // The oversize report carries no pixel and never ends an image.
    a_over_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0 && !o_m_tlast))
        else $error("oversize transfer carries pixel data");

    // The final pixel of an image always lands at address zero.
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[bmp2rgb_pkg::ADDR_W-1:0] == '0))
        else $error("last pixel not at address zero");

    // Pixel parsing only runs on a nonempty image within the column and row ranges.
    a_pixel_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> (r_width != '0 && r_height != '0
                                   && r_col < r_width && r_row < r_height))
        else $error("pixel phase with inconsistent counters");

    // A completed pixel is held until the sink takes it.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("pending pixel dropped or changed");

endmodule
